// File: hw/rtl/sdiv_pkg.sv
package sdiv_pkg;

    localparam int unsigned DATA_W = 64;

    // One restoring step per cell, one cell per quotient bit.
    localparam int unsigned DIV_STEPS = DATA_W;

    // Edges from the accept edge to the edge that takes the result:
    // operand stage, the cell row, result stage.
    localparam int unsigned LATENCY = DIV_STEPS + 2;

    // Token passed from cell to cell.
    // nq starts as the dividend magnitude; each step shifts one dividend bit
    // out at the top and one quotient bit in at the bottom.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] nq;
        logic [DATA_W-1:0] den;
        logic              neg;
        logic              zero;
    } sdiv_stage_t;

endpackage

// File: hw/rtl/sdiv_cell.sv
module sdiv_cell
    import sdiv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sdiv_stage_t stage_in,
    output sdiv_stage_t stage_out
);

    logic              valid_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] nq_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [DATA_W-1:0] rem_shift;
    logic              fits;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] nq_next;

    // Bring in the next dividend bit; the partial remainder stays below the
    // divisor magnitude (at most 2^63), so the shifted value fits in 64 bits.
    always_comb
    begin
        rem_shift = {stage_in.rem[DATA_W-2:0], stage_in.nq[DATA_W-1]};
        fits      = (rem_shift >= stage_in.den);
        rem_next  = fits ? (rem_shift - stage_in.den) : rem_shift;
        nq_next   = {stage_in.nq[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nq_reg   <= nq_next;
        den_reg  <= stage_in.den;
        neg_reg  <= stage_in.neg;
        zero_reg <= stage_in.zero;
    end

    always_comb
    begin
        stage_out.valid = valid_reg;
        stage_out.rem   = rem_reg;
        stage_out.nq    = nq_reg;
        stage_out.den   = den_reg;
        stage_out.neg   = neg_reg;
        stage_out.zero  = zero_reg;
    end

endmodule

// File: hw/rtl/signed_64bit_divider.sv
// Channel   Handshake          Payload                 Notes
// --------  -----------------  ----------------------  ----------------------------
// command   start / busy       dividend, divisor       taken when start && !busy
// result    done (strobe)      quotient                valid for one cycle only
//
// A transaction is accepted in any cycle; busy is held low, so one division
// enters every clock. The accept edge loads the operand stage (magnitudes);
// 64 restoring cells (one quotient bit each) and one result stage (sign and
// zero-divisor fixup) follow in that order, and done rises when the result
// stage is loaded, together with the quotient. Reset clears only the valid
// bits of the pipeline; data in flight is dropped. The receiver cannot stall,
// so no transaction ever waits inside the block.
module signed_64bit_divider
    import sdiv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] dividend,
    input  logic signed [DATA_W-1:0] divisor,
    output logic                     done,
    output logic signed [DATA_W-1:0] quotient
);

    logic              in_valid_reg;
    logic [DATA_W-1:0] num_mag_reg;
    logic [DATA_W-1:0] den_mag_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [DATA_W-1:0] num_mag_next;
    logic [DATA_W-1:0] den_mag_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] quotient_reg;
    logic [DATA_W-1:0] quotient_next;

    sdiv_stage_t       stage [0:DIV_STEPS];

    // The pipeline never backs up, so always take a new transaction.
    assign busy = 1'b0;

    // Two's complement magnitudes; the most negative value maps to 2^63,
    // which is held exactly as an unsigned 64-bit word.
    always_comb
    begin
        num_mag_next = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
        den_mag_next = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    // Operand stage payload: no reset needed.
    always_ff @(posedge clk)
    begin
        num_mag_reg <= num_mag_next;
        den_mag_reg <= den_mag_next;
        neg_reg     <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        zero_reg    <= (divisor == '0);
    end

    // Head of the cell row: remainder starts at zero.
    always_comb
    begin
        stage[0].valid = in_valid_reg;
        stage[0].rem   = '0;
        stage[0].nq    = num_mag_reg;
        stage[0].den   = den_mag_reg;
        stage[0].neg   = neg_reg;
        stage[0].zero  = zero_reg;
    end

    // Row of restoring cells, each resolving one quotient bit, MSB first.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        sdiv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage[i]),
            .stage_out (stage[i+1])
        );
    end

    // Zero divisor forces zero; otherwise apply the sign. Negating the
    // magnitude 2^63 wraps to the most negative value, as required.
    always_comb
    begin
        if (stage[DIV_STEPS].zero)
        begin
            quotient_next = '0;
        end
        else if (stage[DIV_STEPS].neg)
        begin
            quotient_next = ~stage[DIV_STEPS].nq + 1'b1;
        end
        else
        begin
            quotient_next = stage[DIV_STEPS].nq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= stage[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
    end

    assign done     = out_valid_reg;
    assign quotient = quotient_reg;

    // Every strobe traces back to an accepted transaction exactly LATENCY ago.
    a_done_has_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY)
    ) else $error("result strobe without a matching accepted transaction");

    // A zero divisor must give a zero quotient.
    a_zero_divisor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && $past(divisor == '0, LATENCY)) |-> (quotient == '0)
    ) else $error("zero divisor produced a nonzero quotient");

    // Division by one returns the dividend unchanged.
    a_divide_by_one: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && $past(divisor == DATA_W'(1), LATENCY))
            |-> (quotient == $past(dividend, LATENCY))
    ) else $error("division by one altered the dividend");

    // Division by minus one negates the dividend (wrapping at the minimum).
    a_divide_by_minus_one: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && $past(divisor == '1, LATENCY))
            |-> (quotient == (~$past(dividend, LATENCY) + 1'b1))
    ) else $error("division by minus one did not negate the dividend");

endmodule
